### src/kmat_pkg.sv
// ----------------------------------------------------------------------------
// kmat_pkg: shared types and constants
// Field widths, status and action codes, register map and the table way
// record used by the keyed mileage table.
// ----------------------------------------------------------------------------
package kmat_pkg;

  // Beat field widths
  localparam int KEY_HIGH_W = 36;
  localparam int KEY_LOW_W  = 32;
  localparam int CHECK_W    = 4;
  localparam int MILES_W    = 16;
  localparam int TOTAL_W    = 32;
  localparam int STATUS_W   = 3;
  // Stored low key: key_low digits above the check digit
  localparam int STORED_LOW_W = KEY_LOW_W + CHECK_W;

  // Hash: six decimal-weighted nibbles, worst case 1666665 fits in 21 bits
  localparam int HASH_DIGITS = 6;
  localparam int HASH_W      = 21;
  localparam int DIGIT_CNT_W = 3;

  // Default geometry
  localparam int DEFAULT_BUCKETS = 1024;
  localparam int DEFAULT_WAYS    = 4;

  // APB register map: register i at byte address 4*i
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_MIN_MILES = 1'b0;

  // Action codes
  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCUM = 3'd0,
    ST_NEW   = 3'd1,
    ST_FULL  = 3'd2,
    ST_HIT   = 3'd3,
    ST_MISS  = 3'd4
  } status_t;

  // One way of a bucket row
  typedef struct packed {
    logic                    valid;
    logic [KEY_HIGH_W-1:0]   key_high;
    logic [STORED_LOW_W-1:0] key_low;
    logic [TOTAL_W-1:0]      total;
  } way_t;

endpackage

### src/kmat_if.sv
// ----------------------------------------------------------------------------
// kmat_if: request and response channels
// Valid/ready channels carrying one request beat and one response beat.
// ----------------------------------------------------------------------------
interface kmat_req_if
  import kmat_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [KEY_HIGH_W-1:0] key_high;
  logic [KEY_LOW_W-1:0]  key_low;
  logic [CHECK_W-1:0]    check_digit;
  logic [MILES_W-1:0]    flight_miles;

  modport source (
    output valid, action, key_high, key_low, check_digit, flight_miles,
    input  ready
  );
  modport sink (
    input  valid, action, key_high, key_low, check_digit, flight_miles,
    output ready
  );
endinterface

interface kmat_rsp_if
  import kmat_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TOTAL_W-1:0]  total_miles;

  modport source (output valid, status, total_miles, input ready);
  modport sink   (input valid, status, total_miles, output ready);
endinterface

### src/keyed_mileage_accumulate_table_core.sv
// ----------------------------------------------------------------------------
// keyed_mileage_accumulate_table_core: hashed mileage total table
// Set-associative table of identity keys with saturating mileage totals.
// ----------------------------------------------------------------------------
// Usage
//   req carries one beat per item: action (add or query), the 17 BCD key
//   digits split over key_high/key_low, the check digit and flight_miles.
//   rsp returns exactly one beat per item: status and total_miles.
//   min_miles sits at APB byte address 0; write it only while idle.
// Sequence
//   Each item passes in turn through folding the six hash digits, reducing
//   the hash modulo BUCKETS (reciprocal quotient, then remainder), the row
//   read, and a compare/write-back step that also loads the response
//   register, and then returns to idle. Only then is the next item taken:
//   one item is in flight; req.ready is high only in idle.
// Reset
//   rst is synchronous. After reset the block sweeps the row memory, one
//   bucket per cycle, BUCKETS rows in all (1024 by default), clearing
//   every valid bit; req.ready stays low until the sweep ends.
// Stalls
//   The response sits in its own register, so the next request can be
//   taken while rsp waits. If a second result is ready before the first
//   is taken, hold in the compare state until rsp drains.
// ----------------------------------------------------------------------------
module keyed_mileage_accumulate_table_core
  import kmat_pkg::*;
#(
  parameter int BUCKETS = DEFAULT_BUCKETS,
  parameter int WAYS    = DEFAULT_WAYS
) (
  input  logic                  clk,
  input  logic                  rst,
  // APB configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // Item channels
  kmat_req_if.sink              req,
  kmat_rsp_if.source            rsp
);

  localparam int BUCKET_W = $clog2(BUCKETS);
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W    = WAYS * $bits(way_t);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_HASH  = 4'b0100,
    S_LOOK  = 4'b1000
  } state_t;

  state_t state, state_next;

  // Configuration
  logic [MILES_W-1:0]      min_miles;
  logic                    cfg_write;
  logic [REG_IDX_W-1:0]    cfg_idx;

  // Captured item
  logic                    action;
  logic [KEY_HIGH_W-1:0]   key_high;
  logic [STORED_LOW_W-1:0] key_low;
  logic [MILES_W-1:0]      miles;
  logic [MILES_W-1:0]      miles_raised;

  // Clear sweep
  logic [BUCKET_W-1:0]     clr_addr;
  logic                    clr_last;

  // Hash unit
  logic                    req_take;
  logic                    hash_done;
  logic [BUCKET_W-1:0]     bucket;

  // Row memory
  logic                    rd_en;
  logic [ROW_W-1:0]        rd_data;
  logic                    wr_en;
  logic [BUCKET_W-1:0]     wr_addr;
  logic [ROW_W-1:0]        wr_data;
  way_t [WAYS-1:0]         row_rd;
  way_t [WAYS-1:0]         row_new;

  // Compare results
  logic                    hit;
  logic [WAY_W-1:0]        hit_way;
  logic                    free;
  logic [WAY_W-1:0]        free_way;
  logic [TOTAL_W:0]        sum;
  logic [TOTAL_W-1:0]      sum_sat;
  logic [TOTAL_W-1:0]      miles_ext;
  way_t                    way_upd;
  logic                    look_write;
  logic                    rsp_load;
  status_t                 status_next;
  logic [TOTAL_W-1:0]      total_next;

  // Response register
  logic                    rsp_valid;
  status_t                 status;
  logic [TOTAL_W-1:0]      total_miles;

  // --------------------------------------------------------------------------
  // APB: always ready, write completes on the access phase
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_idx   = paddr[APB_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_miles <= '0;
    end else if (cfg_write && cfg_idx == REG_MIN_MILES) begin
      min_miles <= pwdata[MILES_W-1:0];
    end
  end

  assign prdata = (cfg_idx == REG_MIN_MILES) ?
                  {{(APB_DATA_W - MILES_W){1'b0}}, min_miles} : '0;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign req.ready = (state == S_IDLE);
  assign req_take  = req.valid && req.ready;
  assign clr_last  = (clr_addr == BUCKET_W'(BUCKETS - 1));
  assign rsp_load  = (state == S_LOOK) && (!rsp_valid || rsp.ready);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_last) state_next = S_IDLE;
      S_IDLE:  if (req_take) state_next = S_HASH;
      S_HASH:  if (hash_done) state_next = S_LOOK;
      S_LOOK:  if (rsp_load) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // Raise miles to the configured floor as the beat is taken
  assign miles_raised = (req.flight_miles < min_miles) ? min_miles : req.flight_miles;

  always_ff @(posedge clk) begin
    if (req_take) begin
      action   <= req.action;
      key_high <= req.key_high;
      key_low  <= {req.key_low, req.check_digit};
      miles    <= miles_raised;
    end
  end

  // --------------------------------------------------------------------------
  // Bucket index: shared iterative step unit
  // --------------------------------------------------------------------------
  kmat_hash_unit #(
    .BUCKETS (BUCKETS)
  ) u_hash (
    .clk         (clk),
    .rst         (rst),
    .start       (req_take),
    .key_low     (req.key_low),
    .check_digit (req.check_digit),
    .done        (hash_done),
    .bucket      (bucket)
  );

  // --------------------------------------------------------------------------
  // Row memory: read once the index is known, write back in the look cycle;
  // the reset sweep writes all-zero rows
  // --------------------------------------------------------------------------
  assign rd_en   = (state == S_HASH) && hash_done;
  assign wr_en   = (state == S_CLEAR) || look_write;
  assign wr_addr = (state == S_CLEAR) ? clr_addr : bucket;
  assign wr_data = (state == S_CLEAR) ? '0 : row_new;
  assign row_rd  = rd_data;

  kmat_row_ram #(
    .DEPTH (BUCKETS),
    .ROW_W (ROW_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (bucket),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  kmat_way_match #(
    .WAYS (WAYS)
  ) u_match (
    .row      (row_rd),
    .key_high (key_high),
    .key_low  (key_low),
    .hit      (hit),
    .hit_way  (hit_way),
    .free     (free),
    .free_way (free_way)
  );

  // --------------------------------------------------------------------------
  // Update and result: saturate the running total, or claim the free way
  // --------------------------------------------------------------------------
  assign miles_ext = {{(TOTAL_W - MILES_W){1'b0}}, miles};
  assign sum       = {1'b0, row_rd[hit_way].total} + {1'b0, miles_ext};
  assign sum_sat   = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];

  always_comb begin
    way_upd.valid    = 1'b1;
    way_upd.key_high = key_high;
    way_upd.key_low  = key_low;
    way_upd.total    = hit ? sum_sat : miles_ext;
    row_new          = row_rd;
    row_new[hit ? hit_way : free_way] = way_upd;
  end

  assign look_write = rsp_load && (action == ACT_ADD) && (hit || free);

  always_comb begin
    if (action == ACT_QUERY) begin
      status_next = hit ? ST_HIT : ST_MISS;
      total_next  = hit ? row_rd[hit_way].total : '0;
    end else if (hit) begin
      status_next = ST_ACCUM;
      total_next  = sum_sat;
    end else if (free) begin
      status_next = ST_NEW;
      total_next  = miles_ext;
    end else begin
      // Bucket full: drop the item, table untouched
      status_next = ST_FULL;
      total_next  = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Response register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      status      <= status_next;
      total_miles <= total_next;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = status;
  assign rsp.total_miles = total_miles;

endmodule

### src/kmat_row_ram.sv
// ----------------------------------------------------------------------------
// kmat_row_ram: bucket row memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module kmat_row_ram #(
  parameter int DEPTH = 1024,
  parameter int ROW_W = 420
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [ROW_W-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [ROW_W-1:0]         wr_data
);

  logic [ROW_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/kmat_hash_unit.sv
// ----------------------------------------------------------------------------
// kmat_hash_unit: iterative bucket index unit
// One shared step datapath folds six nibbles as acc*10+digit, then the hash
// is reduced modulo BUCKETS by a reciprocal multiply and one correction.
// ----------------------------------------------------------------------------
module kmat_hash_unit
  import kmat_pkg::*;
#(
  parameter int BUCKETS = DEFAULT_BUCKETS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [KEY_LOW_W-1:0]       key_low,
  input  logic [CHECK_W-1:0]         check_digit,
  output logic                       done,
  output logic [$clog2(BUCKETS)-1:0] bucket
);

  localparam int BUCKET_W = $clog2(BUCKETS);
  localparam int REM_W    = BUCKET_W + 1;
  localparam int DIGS_W   = HASH_DIGITS * CHECK_W;
  localparam int PROD_W   = 2 * HASH_W;
  // floor(2^HASH_W / BUCKETS): the quotient estimate is low by at most one
  localparam logic [HASH_W-1:0] RECIP = HASH_W'((1 << HASH_W) / BUCKETS);

  typedef enum logic [3:0] {
    H_IDLE  = 4'b0001,
    H_DIGIT = 4'b0010,
    H_QUOT  = 4'b0100,
    H_REM   = 4'b1000
  } hphase_t;

  hphase_t                phase, phase_next;
  logic [DIGIT_CNT_W-1:0] dcnt;
  logic [DIGS_W-1:0]      digits;
  logic [HASH_W-1:0]      acc;
  logic [HASH_W-1:0]      quot;
  logic [REM_W-1:0]       rem;
  logic [HASH_W-1:0]      fold;
  logic [PROD_W-1:0]      prod;
  logic [HASH_W-1:0]      quot_b;
  logic [HASH_W-1:0]      diff;

  // Shared step datapath
  always_comb begin
    fold   = {acc[HASH_W-4:0], 3'b000} + {acc[HASH_W-2:0], 1'b0}
           + HASH_W'(digits[DIGS_W-1 -: CHECK_W]);
    prod   = PROD_W'(acc) * PROD_W'(RECIP);
    quot_b = quot * HASH_W'(BUCKETS);
    diff   = acc - quot_b;
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      H_IDLE:  if (start) phase_next = H_DIGIT;
      H_DIGIT: if (dcnt == DIGIT_CNT_W'(HASH_DIGITS - 1)) phase_next = H_QUOT;
      H_QUOT:  phase_next = H_REM;
      H_REM:   phase_next = H_IDLE;
      default: phase_next = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= H_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= (phase == H_REM);
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      H_IDLE: begin
        if (start) begin
          digits <= {key_low[31:28], key_low[23:20], key_low[19:16],
                     key_low[7:4], key_low[3:0], check_digit};
          acc    <= '0;
          dcnt   <= '0;
        end
      end
      H_DIGIT: begin
        acc    <= fold;
        digits <= {digits[DIGS_W-CHECK_W-1:0], {CHECK_W{1'b0}}};
        dcnt   <= dcnt + 1'b1;
      end
      H_QUOT: begin
        quot <= prod[PROD_W-1 -: HASH_W];
      end
      H_REM: begin
        // Remainder lands below twice BUCKETS
        rem <= diff[REM_W-1:0];
      end
      default: ;
    endcase
  end

  assign bucket = (rem >= REM_W'(BUCKETS)) ? BUCKET_W'(rem - REM_W'(BUCKETS))
                                           : rem[BUCKET_W-1:0];

endmodule

### src/kmat_way_match.sv
// ----------------------------------------------------------------------------
// kmat_way_match: bucket way compare
// Compares the key against every way of a row; reports the lowest valid
// matching way and the lowest free way.
// ----------------------------------------------------------------------------
module kmat_way_match
  import kmat_pkg::*;
#(
  parameter int WAYS = DEFAULT_WAYS
) (
  input  way_t [WAYS-1:0]                        row,
  input  logic [KEY_HIGH_W-1:0]                  key_high,
  input  logic [STORED_LOW_W-1:0]                key_low,
  output logic                                   hit,
  output logic [(WAYS > 1 ? $clog2(WAYS) : 1)-1:0] hit_way,
  output logic                                   free,
  output logic [(WAYS > 1 ? $clog2(WAYS) : 1)-1:0] free_way
);

  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  // Walk down so the lowest way wins
  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    free     = 1'b0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row[w].valid) begin
        if (row[w].key_high == key_high && row[w].key_low == key_low) begin
          hit     = 1'b1;
          hit_way = WAY_W'(w);
        end
      end else begin
        free     = 1'b1;
        free_way = WAY_W'(w);
      end
    end
  end

endmodule

### src/kmat_checker.sv
// ----------------------------------------------------------------------------
// kmat_checker: port-level checks for the mileage table
// Watches reset sweep, one-item-at-a-time flow and response contents.
// ----------------------------------------------------------------------------
module kmat_checker
  import kmat_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] rsp_status,
  input logic [TOTAL_W-1:0]  rsp_total
);

  // Clear sweep follows reset: no request taken right after it
  a_reset_blocks: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request ready right after reset");

  // One item in flight: a taken beat closes the request side
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while an item is in flight");

  // Dropped adds and misses carry a zero total
  a_zero_total: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_MISS)) |->
      (rsp_total == '0))
    else $error("nonzero total on drop or miss");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status <= ST_MISS))
    else $error("undefined status code");

  // A stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_status) && $stable(rsp_total)))
    else $error("response beat changed while stalled");

endmodule

bind keyed_mileage_accumulate_table_core kmat_checker u_kmat_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_total  (rsp.total_miles)
);
